@@ hw/rtl/opa_pkg.sv @@
// ----------------------------------------------------------------------------
// opa_pkg
// Shared types and constants of the oriented permutation apply block.
// ----------------------------------------------------------------------------
package opa_pkg;

  localparam int POS_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int ENTRY_W   = 7;
  localparam int MOD_VEC_W = 62;
  localparam int CFG_IDX_W = 2;

  // command codes
  localparam logic [1:0] CMD_LOAD_STATE = 2'd0;
  localparam logic [1:0] CMD_LOAD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_APPLY      = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORI_MODULI  = 2'd1;

  localparam logic [POS_W-1:0] PIECE_COUNT_RST = 5'd31;

  // operands of the shared twist unit
  typedef struct packed {
    logic [BYTE_W-1:0] src;
    logic [1:0]        twist;
    logic [1:0]        modulus;
  } opa_twist_t;

endpackage

@@ hw/rtl/opa_twist_unit.sv @@
// ----------------------------------------------------------------------------
// opa_twist_unit
// Adds an orientation twist to a state byte and reduces it once by the
// orientation modulus of the source position.
// ----------------------------------------------------------------------------
module opa_twist_unit import opa_pkg::*; (
  input  opa_twist_t        op_i,
  output logic [BYTE_W-1:0] result_o
);

  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] mod_val;

  // twist and modulus both live in bits 5-6, sum wraps at 8 bits
  assign sum      = op_i.src + {1'b0, op_i.twist, 5'b0};
  assign mod_val  = {1'b0, op_i.modulus, 5'b0};
  assign result_o = (sum >= mod_val) ? (sum - mod_val) : sum;

endmodule

@@ hw/rtl/oriented_permutation_apply.sv @@
// ----------------------------------------------------------------------------
// oriented_permutation_apply
// Piece state of up to MAX_SLOTS bytes with a table of moves; applies a
// move by permuting and twisting the state through one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (in_valid_i / in_stall_o) carries cmd_i, move_index_i,
//   slot_i and value_i. Stall is high whenever a command is in progress.
//   Load state byte and load move entry finish in the cycle they are taken.
//   Apply streams n = min(piece_count, MAX_SLOTS) move entries through a
//   three-stage read/twist pipeline into a scratch memory, then copies
//   the scratch back into the state. Read state returns n transactions on
//   the result channel (out_valid_o / out_stall_i) with last_o on the final
//   slot; each byte goes through the single state memory read port, then
//   waits out any receiver stall, and a stalled result holds its value.
//   Apply or read with zero pieces in use, loads with an out of range slot,
//   and apply or load move with an out of range move index do nothing.
//   Configuration writes (cfg_valid_i, always ready) set piece_count
//   (index 0) and orientation_moduli (index 1) while the block is idle (a
//   user rule, not enforced). Reset clears the state bytes to zero through
//   per-slot valid bits, piece_count to 31 and the moduli to zero; the move
//   table is undefined until loaded. No clearing pass is needed.
// ----------------------------------------------------------------------------
module oriented_permutation_apply import opa_pkg::*; #(
  parameter int MAX_SLOTS = 31,
  parameter int MAX_MOVES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [5:0]           move_index_i,
  input  logic [POS_W-1:0]     slot_i,
  input  logic [BYTE_W-1:0]    value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [POS_W-1:0]     slot_out_o,
  output logic [BYTE_W-1:0]    piece_value_o,
  output logic                 last_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MOD_VEC_W-1:0] cfg_data_i
);

  localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int MT_DEPTH = MAX_MOVES * 32;
  localparam int MT_AW   = $clog2(MT_DEPTH);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_APPLY    = 3'd1;
  localparam logic [2:0] ST_COPY     = 3'd2;
  localparam logic [2:0] ST_RD_ISSUE = 3'd3;
  localparam logic [2:0] ST_RD_LOAD  = 3'd4;
  localparam logic [2:0] ST_RD_HOLD  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [POS_W-1:0]     count_q;
  logic [MOD_VEC_W-1:0] moduli_q;
  logic [POS_W-1:0]     n_eff;
  logic [63:0]          mods_ext;

  logic                 in_acc;
  logic                 slot_ok;
  logic                 row_ok;

  // memories
  logic [ENTRY_W-1:0]   move_mem [MT_DEPTH];
  logic [BYTE_W-1:0]    piece_mem [MAX_SLOTS];
  logic [BYTE_W-1:0]    scratch_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] piece_vld_q;

  logic                 mw_en;
  logic [MT_AW-1:0]     mw_addr;
  logic [MT_AW-1:0]     mr_addr;
  logic [ENTRY_W-1:0]   mt_rd_q;

  logic                 pw_en;
  logic [SLOT_W-1:0]    pw_addr;
  logic [BYTE_W-1:0]    pw_data;
  logic [SLOT_W-1:0]    pr_addr;
  logic [BYTE_W-1:0]    piece_rd_q;
  logic                 piece_rd_vld_q;
  logic [BYTE_W-1:0]    piece_data;

  logic [BYTE_W-1:0]    scratch_rd_q;

  // apply pipeline
  logic [5:0]           row_q;
  logic [POS_W-1:0]     ai_q;
  logic                 s1_v_q;
  logic [POS_W-1:0]     s1_idx_q;
  logic                 s2_v_q;
  logic [POS_W-1:0]     s2_idx_q;
  logic [1:0]           s2_twist_q;
  logic [1:0]           s2_mod_q;
  logic                 s2_inr_q;
  logic [POS_W-1:0]     src_pos;
  opa_twist_t           twist_op;
  logic [BYTE_W-1:0]    twist_res;

  // copy and readout
  logic [POS_W-1:0]     ci_q;
  logic                 c1_v_q;
  logic [POS_W-1:0]     c1_idx_q;
  logic [POS_W-1:0]     rd_idx_q;
  logic                 out_valid_q;
  logic [POS_W-1:0]     slot_out_q;
  logic [BYTE_W-1:0]    piece_value_q;
  logic                 last_q;

  assign n_eff    = (32'(count_q) < MAX_SLOTS) ? count_q : POS_W'(MAX_SLOTS);
  assign mods_ext = {2'b00, moduli_q};
  assign in_acc   = in_valid_i && !in_stall_o;
  assign slot_ok  = 32'(slot_i) < MAX_SLOTS;
  assign row_ok   = 32'(move_index_i) < MAX_MOVES;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign slot_out_o    = slot_out_q;
  assign piece_value_o = piece_value_q;
  assign last_o        = last_q;

  // ---------------- move table ----------------
  assign mw_en   = in_acc && (cmd_i == CMD_LOAD_MOVE) && slot_ok && row_ok;
  assign mw_addr = MT_AW'({move_index_i, slot_i});
  assign mr_addr = MT_AW'({row_q, ai_q});

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      move_mem[mw_addr] <= value_i[ENTRY_W-1:0];
    end
    mt_rd_q <= move_mem[mr_addr];
  end

  // ---------------- piece state ----------------
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = slot_i[SLOT_W-1:0];
    pw_data = value_i;
    if (in_acc && (cmd_i == CMD_LOAD_STATE) && slot_ok) begin
      pw_en = 1'b1;
    end
    if ((state_q == ST_COPY) && c1_v_q) begin
      pw_en   = 1'b1;
      pw_addr = c1_idx_q[SLOT_W-1:0];
      pw_data = scratch_rd_q;
    end
  end

  assign src_pos = mt_rd_q[POS_W-1:0];
  assign pr_addr = (state_q == ST_APPLY) ? src_pos[SLOT_W-1:0] : rd_idx_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      piece_mem[pw_addr] <= pw_data;
    end
    piece_rd_q <= piece_mem[pr_addr];
  end

  // never-written slots read as zero
  assign piece_data = piece_rd_vld_q ? piece_rd_q : '0;

  // ---------------- scratch state ----------------
  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      scratch_mem[s2_idx_q[SLOT_W-1:0]] <= twist_res;
    end
    scratch_rd_q <= scratch_mem[ci_q[SLOT_W-1:0]];
  end

  // ---------------- shared twist unit ----------------
  always_comb begin
    twist_op.src     = s2_inr_q ? piece_data : '0;
    twist_op.twist   = s2_twist_q;
    twist_op.modulus = s2_mod_q;
  end

  opa_twist_unit u_twist (
    .op_i     (twist_op),
    .result_o (twist_res)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if ((cmd_i == CMD_APPLY) && row_ok && (n_eff != '0)) begin
            state_d = ST_APPLY;
          end else if ((cmd_i == CMD_READ) && (n_eff != '0)) begin
            state_d = ST_RD_ISSUE;
          end
        end
      end
      ST_APPLY: begin
        if ((ai_q == n_eff) && !s1_v_q && !s2_v_q) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if ((ci_q == n_eff) && !c1_v_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_ISSUE: state_d = ST_RD_LOAD;
      ST_RD_LOAD:  state_d = ST_RD_HOLD;
      ST_RD_HOLD: begin
        if (!out_stall_i) begin
          state_d = last_q ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= PIECE_COUNT_RST;
      moduli_q       <= '0;
      piece_vld_q    <= '0;
      piece_rd_vld_q <= 1'b0;
      row_q          <= '0;
      ai_q           <= '0;
      s1_v_q         <= 1'b0;
      s1_idx_q       <= '0;
      s2_v_q         <= 1'b0;
      s2_idx_q       <= '0;
      s2_twist_q     <= '0;
      s2_mod_q       <= '0;
      s2_inr_q       <= 1'b0;
      ci_q           <= '0;
      c1_v_q         <= 1'b0;
      c1_idx_q       <= '0;
      rd_idx_q       <= '0;
      out_valid_q    <= 1'b0;
      slot_out_q     <= '0;
      piece_value_q  <= '0;
      last_q         <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_PIECE_COUNT) begin
          count_q <= cfg_data_i[POS_W-1:0];
        end else if (cfg_index_i == CFG_ORI_MODULI) begin
          moduli_q <= cfg_data_i;
        end
      end

      if (pw_en) begin
        piece_vld_q[pw_addr] <= 1'b1;
      end
      piece_rd_vld_q <= piece_vld_q[pr_addr];

      if (in_acc) begin
        row_q    <= move_index_i;
        ai_q     <= '0;
        ci_q     <= '0;
        rd_idx_q <= '0;
      end

      // apply: issue entry read, then state read, then twist and store
      if (state_q == ST_APPLY) begin
        s1_v_q <= (ai_q < n_eff);
        if (ai_q < n_eff) begin
          ai_q     <= ai_q + 1'b1;
          s1_idx_q <= ai_q;
        end
      end
      s2_v_q     <= s1_v_q;
      s2_idx_q   <= s1_idx_q;
      s2_twist_q <= mt_rd_q[6:5];
      s2_mod_q   <= mods_ext[{src_pos, 1'b0} +: 2];
      s2_inr_q   <= (src_pos < n_eff);

      // copy scratch back into the state
      if (state_q == ST_COPY) begin
        c1_v_q <= (ci_q < n_eff);
        if (ci_q < n_eff) begin
          ci_q     <= ci_q + 1'b1;
          c1_idx_q <= ci_q;
        end
      end else begin
        c1_v_q <= 1'b0;
      end

      // readout
      if (state_q == ST_RD_LOAD) begin
        out_valid_q   <= 1'b1;
        slot_out_q    <= rd_idx_q;
        piece_value_q <= piece_data;
        last_q        <= ((rd_idx_q + 1'b1) == n_eff);
      end
      if ((state_q == ST_RD_HOLD) && !out_stall_i) begin
        out_valid_q <= 1'b0;
        rd_idx_q    <= rd_idx_q + 1'b1;
      end
    end
  end

endmodule
